### hw/rtl/slbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbr_pkg
// Shared types, constants and a helper function of the scanline line buffer.
// ----------------------------------------------------------------------------
package slbr_pkg;

    // Line store geometry.
    localparam int unsigned LINE_CELLS = 160;
    localparam int unsigned LS_AW      = $clog2(LINE_CELLS);
    localparam int unsigned CELL_W     = 5;

    // Color table geometry.
    localparam int unsigned COLOR_ENTRIES = 32;
    localparam int unsigned CIDX_W        = 5;

    // Command queue between the front and the back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Configuration port.
    localparam int unsigned CFG_IW        = 1;
    localparam int unsigned CFG_DW        = 2;
    localparam logic [CFG_IW-1:0] CFG_KANGAROO  = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_READ_MODE = 1'd1;

    // Request type codes on the input channel.
    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_BYTE  = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_COLOR = 3'd4;

    // Read mode codes.
    localparam logic [1:0] RM_DOUBLE  = 2'd0;
    localparam logic [1:0] RM_NONE    = 2'd1;
    localparam logic [1:0] RM_SPLIT_A = 2'd2;
    localparam logic [1:0] RM_SPLIT_B = 2'd3;

    // Operations carried from the front to the back.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_START,
        OP_CELLS,
        OP_READ,
        OP_COLOR
    } op_t;

    // One classified command. The pos field holds the start position, the
    // cell index or the color index, depending on the operation.
    typedef struct packed {
        op_t                          op;
        logic [7:0]                   pos;
        logic [7:0]                   value;
        logic                         wide;
        logic [3:0]                   opaque;
        logic [3:0][CELL_W-1:0]       cells;
    } cmd_t;

    // Color table address for a cell value: entries whose low two bits are
    // zero all map to the background entry.
    function automatic logic [CIDX_W-1:0] color_addr(input logic [CELL_W-1:0] v);
        color_addr = (v[1:0] == 2'b00) ? '0 : v;
    endfunction

endpackage

### hw/rtl/scanline_line_buffer_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_line_buffer_renderer
// Line buffer with palette lookup: assembles one scanline of 5-bit cells and
// reads cells out as pairs of colors through a 32-entry color table.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Handshake          | Moves
//  s_*       | in        | s_valid / s_ready  | one request transaction
//  m_*       | out       | m_valid / m_ready  | one pair of colors per read
//  cfg_*     | in        | cfg_we             | kangaroo mode, read mode
//
// The front takes a request transaction every cycle while the two-entry
// command queue has room. The back carries out clear, start and color
// writes when it pops them. A graphic byte is popped and then written out
// as two cells if wide or four if narrow, through the single line store
// write port. A read holds the back through three steps: pop with the line
// store read, color table read, result load.
// Clear resets all per-cell valid bits together; there is no sweep.
// Reset is synchronous and active low; a stalled result holds the back in
// its final read step while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module scanline_line_buffer_renderer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_req_type,
    input  logic [2:0]                  s_palette_bits,
    input  logic [7:0]                  s_start_hpos,
    input  logic                        s_sets_write_mode,
    input  logic                        s_wide_mode_in,
    input  logic [7:0]                  s_graphic_data,
    input  logic [15:0]                 s_fetch_address,
    input  logic                        s_holey_4k,
    input  logic                        s_holey_2k,
    input  logic [7:0]                  s_cell_index,
    input  logic [4:0]                  s_color_index,
    input  logic [7:0]                  s_color_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_left_color,
    output logic [7:0]                  m_right_color,
    output logic                        m_pixels_valid,
    input  logic                        cfg_we,
    input  logic [slbr_pkg::CFG_IW-1:0] cfg_index,
    input  logic [slbr_pkg::CFG_DW-1:0] cfg_wdata
);
    import slbr_pkg::*;

    logic q_wr_valid;
    logic q_wr_ready;
    cmd_t q_wr_cmd;
    logic q_rd_valid;
    logic q_rd_ready;
    cmd_t q_rd_cmd;

    // Request intake and classification.
    slbr_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_palette_bits    (s_palette_bits),
        .s_start_hpos      (s_start_hpos),
        .s_sets_write_mode (s_sets_write_mode),
        .s_wide_mode_in    (s_wide_mode_in),
        .s_graphic_data    (s_graphic_data),
        .s_fetch_address   (s_fetch_address),
        .s_holey_4k        (s_holey_4k),
        .s_holey_2k        (s_holey_2k),
        .s_cell_index      (s_cell_index),
        .s_color_index     (s_color_index),
        .s_color_value     (s_color_value),
        .q_wr_valid        (q_wr_valid),
        .q_wr_ready        (q_wr_ready),
        .q_wr_cmd          (q_wr_cmd)
    );

    // Command queue.
    slbr_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_cmd   (q_wr_cmd),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_cmd   (q_rd_cmd)
    );

    // Command execution and result output.
    slbr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_rd_valid),
        .q_ready        (q_rd_ready),
        .q_cmd          (q_rd_cmd),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_color   (m_left_color),
        .m_right_color  (m_right_color),
        .m_pixels_valid (m_pixels_valid)
    );

endmodule

### hw/rtl/slbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbr_front
// Accepts input transactions, tracks palette and wide mode, and turns each
// known request into a command, with the cells of a graphic byte split out.
// ----------------------------------------------------------------------------
module slbr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_req_type,
    input  logic [2:0]          s_palette_bits,
    input  logic [7:0]          s_start_hpos,
    input  logic                s_sets_write_mode,
    input  logic                s_wide_mode_in,
    input  logic [7:0]          s_graphic_data,
    input  logic [15:0]         s_fetch_address,
    input  logic                s_holey_4k,
    input  logic                s_holey_2k,
    input  logic [7:0]          s_cell_index,
    input  logic [4:0]          s_color_index,
    input  logic [7:0]          s_color_value,
    output logic                q_wr_valid,
    input  logic                q_wr_ready,
    output slbr_pkg::cmd_t      q_wr_cmd
);
    import slbr_pkg::*;

    logic [2:0] palette_reg;
    logic [2:0] palette_next;
    logic       wide_reg;
    logic       wide_next;
    logic       known;
    logic       holey;
    logic       accept;
    logic [3:0] wide_a;
    logic [3:0] wide_b;
    cmd_t       cmd;

    assign s_ready = q_wr_ready;
    assign accept  = s_valid && s_ready;

    // A fetch from the upper half of the address space can fall in a hole.
    assign holey = s_fetch_address[15] &&
                   ((s_holey_4k && s_fetch_address[12]) ||
                    (s_holey_2k && s_fetch_address[11]));

    assign wide_a = {s_graphic_data[3:2], s_graphic_data[7:6]};
    assign wide_b = {s_graphic_data[1:0], s_graphic_data[5:4]};

    // Classify the request and prepare the command payload.
    always_comb begin
        cmd        = '0;
        known      = 1'b1;
        cmd.op     = OP_CLEAR;
        cmd.wide   = wide_reg;
        unique case (s_req_type)
            REQ_CLEAR: begin
                cmd.op = OP_CLEAR;
            end
            REQ_START: begin
                cmd.op  = OP_START;
                cmd.pos = s_start_hpos;
            end
            REQ_BYTE: begin
                cmd.op = OP_CELLS;
                if (wide_reg) begin
                    cmd.cells[0]  = {palette_reg[2], wide_a};
                    cmd.cells[1]  = {palette_reg[2], wide_b};
                    cmd.opaque[0] = !holey && (wide_a != 4'd0);
                    cmd.opaque[1] = !holey && (wide_b != 4'd0);
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        cmd.cells[k]  = {palette_reg, s_graphic_data[7-2*k -: 2]};
                        cmd.opaque[k] = !holey && (s_graphic_data[7-2*k -: 2] != 2'd0);
                    end
                end
            end
            REQ_READ: begin
                cmd.op  = OP_READ;
                cmd.pos = s_cell_index;
            end
            REQ_COLOR: begin
                cmd.op    = OP_COLOR;
                cmd.pos   = {3'd0, s_color_index};
                cmd.value = s_color_value;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Unknown requests are accepted and dropped here.
    assign q_wr_valid = s_valid && known;
    assign q_wr_cmd   = cmd;

    // Object state that shapes how later graphic bytes split.
    always_comb begin
        palette_next = palette_reg;
        wide_next    = wide_reg;
        if (accept && (s_req_type == REQ_START)) begin
            palette_next = s_palette_bits;
            if (s_sets_write_mode) begin
                wide_next = s_wide_mode_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_reg <= '0;
            wide_reg    <= 1'b0;
        end else begin
            palette_reg <= palette_next;
            wide_reg    <= wide_next;
        end
    end

endmodule

### hw/rtl/slbr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbr_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module slbr_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  slbr_pkg::cmd_t      wr_cmd,
    output logic                rd_valid,
    input  logic                rd_ready,
    output slbr_pkg::cmd_t      rd_cmd
);
    import slbr_pkg::*;

    cmd_t            q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = q_mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### hw/rtl/slbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbr_back
// Executes commands: owns the line store, the color table, the horizontal
// position, the configuration registers and the result register.
// ----------------------------------------------------------------------------
module slbr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  slbr_pkg::cmd_t              q_cmd,
    input  logic                        cfg_we,
    input  logic [slbr_pkg::CFG_IW-1:0] cfg_index,
    input  logic [slbr_pkg::CFG_DW-1:0] cfg_wdata,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_left_color,
    output logic [7:0]                  m_right_color,
    output logic                        m_pixels_valid
);
    import slbr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CELLS = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_SEND  = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;

    logic [7:0]              hpos_reg;
    logic [7:0]              hpos_next;
    logic [3:0][CELL_W-1:0]  cells_reg;
    logic [3:0]              opaque_reg;
    logic                    wide_reg;
    logic [1:0]              cnt_reg;
    logic [1:0]              cnt_next;
    logic                    kangaroo_reg;
    logic [1:0]              read_mode_reg;

    // Line store and its per-entry valid bits.
    logic [CELL_W-1:0]       ls_mem [LINE_CELLS];
    logic [LINE_CELLS-1:0]   ls_vld_reg;
    logic [CELL_W-1:0]       ls_rd_data_reg;
    logic                    ls_rd_hit_reg;
    logic                    ls_we;
    logic [LS_AW-1:0]        ls_waddr;
    logic [CELL_W-1:0]       ls_wdata;
    logic                    ls_re;
    logic [LS_AW-1:0]        ls_raddr;
    logic                    ls_clear;
    logic                    hpos_in_range;
    logic                    rd_in_range;

    // Color table and its per-entry valid bits.
    logic [7:0]              cmem [COLOR_ENTRIES];
    logic [COLOR_ENTRIES-1:0] cvld_reg;
    logic [7:0]              cl_data_reg;
    logic [7:0]              cr_data_reg;
    logic                    cl_hit_reg;
    logic                    cr_hit_reg;
    logic                    c_we;
    logic [CIDX_W-1:0]       c_waddr;
    logic                    c_re;
    logic [CELL_W-1:0]       cell_val;
    logic [CELL_W-1:0]       l_val;
    logic [CELL_W-1:0]       r_val;
    logic [CIDX_W-1:0]       l_addr;
    logic [CIDX_W-1:0]       r_addr;

    // Result register.
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic [7:0]              m_left_reg;
    logic [7:0]              m_right_reg;
    logic                    m_pix_reg;
    logic                    m_load;

    logic                    pop;
    logic                    last_cell;

    assign q_ready = (state_reg == ST_IDLE);
    assign pop     = q_valid && q_ready;

    assign hpos_in_range = ({1'b0, hpos_reg} < 9'(LINE_CELLS));
    assign rd_in_range   = ({1'b0, q_cmd.pos} < 9'(LINE_CELLS));
    assign last_cell     = (cnt_reg == (wide_reg ? 2'd1 : 2'd3));

    // Line store access decode.
    assign ls_we    = (state_reg == ST_CELLS) && hpos_in_range &&
                      (opaque_reg[cnt_reg] || kangaroo_reg);
    assign ls_waddr = hpos_reg[LS_AW-1:0];
    assign ls_wdata = opaque_reg[cnt_reg] ? cells_reg[cnt_reg] : '0;
    assign ls_re    = pop && (q_cmd.op == OP_READ);
    assign ls_raddr = q_cmd.pos[LS_AW-1:0];
    assign ls_clear = pop && (q_cmd.op == OP_CLEAR);

    // Color table access decode.
    assign c_we    = pop && (q_cmd.op == OP_COLOR);
    assign c_waddr = q_cmd.pos[CIDX_W-1:0];
    assign c_re    = (state_reg == ST_FETCH);

    // Split the stored cell into the two pixel values by read mode.
    assign cell_val = ls_rd_hit_reg ? ls_rd_data_reg : '0;
    always_comb begin
        unique case (read_mode_reg)
            RM_SPLIT_A: begin
                l_val = {cell_val[4], 2'b00, cell_val[1], cell_val[3]};
                r_val = {cell_val[4], 2'b00, cell_val[0], cell_val[2]};
            end
            RM_SPLIT_B: begin
                l_val = {cell_val[4:1], 1'b0};
                r_val = {cell_val[4:2], cell_val[0], 1'b0};
            end
            RM_DOUBLE, RM_NONE: begin
                l_val = cell_val;
                r_val = cell_val;
            end
        endcase
    end
    assign l_addr = color_addr(l_val);
    assign r_addr = color_addr(r_val);

    // Result register takes new data when empty or being drained.
    assign m_load = (state_reg == ST_SEND) && (!m_valid_reg || m_ready);
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Sequencer and position update.
    always_comb begin
        state_next = state_reg;
        hpos_next  = hpos_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = 2'd0;
                if (pop) begin
                    unique case (q_cmd.op)
                        OP_START: hpos_next  = q_cmd.pos;
                        OP_CELLS: state_next = ST_CELLS;
                        OP_READ:  state_next = ST_FETCH;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CELLS: begin
                hpos_next = hpos_reg + 8'd1;
                cnt_next  = cnt_reg + 2'd1;
                if (last_cell) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hpos_reg      <= '0;
            cnt_reg       <= '0;
            kangaroo_reg  <= 1'b0;
            read_mode_reg <= RM_DOUBLE;
            ls_vld_reg    <= '0;
            cvld_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hpos_reg    <= hpos_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (ls_clear) begin
                ls_vld_reg <= '0;
            end else if (ls_we) begin
                ls_vld_reg[ls_waddr] <= 1'b1;
            end
            if (c_we) begin
                cvld_reg[c_waddr] <= 1'b1;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KANGAROO:  kangaroo_reg  <= cfg_wdata[0];
                    CFG_READ_MODE: read_mode_reg <= cfg_wdata;
                endcase
            end
        end
    end

    // Payload registers of the command being carried out.
    always_ff @(posedge aclk) begin
        if (pop && (q_cmd.op == OP_CELLS)) begin
            cells_reg  <= q_cmd.cells;
            opaque_reg <= q_cmd.opaque;
            wide_reg   <= q_cmd.wide;
        end
        if (ls_re) begin
            ls_rd_hit_reg <= rd_in_range && ls_vld_reg[ls_raddr];
        end
        if (c_re) begin
            cl_hit_reg <= cvld_reg[l_addr];
            cr_hit_reg <= cvld_reg[r_addr];
        end
        if (m_load) begin
            m_pix_reg   <= (read_mode_reg != RM_NONE);
            m_left_reg  <= ((read_mode_reg != RM_NONE) && cl_hit_reg) ? cl_data_reg : 8'd0;
            m_right_reg <= ((read_mode_reg != RM_NONE) && cr_hit_reg) ? cr_data_reg : 8'd0;
        end
    end

    // Line store memory.
    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[ls_waddr] <= ls_wdata;
        end
        if (ls_re) begin
            ls_rd_data_reg <= ls_mem[ls_raddr];
        end
    end

    // Color table memory with two read ports.
    always_ff @(posedge aclk) begin
        if (c_we) begin
            cmem[c_waddr] <= q_cmd.value;
        end
        if (c_re) begin
            cl_data_reg <= cmem[l_addr];
            cr_data_reg <= cmem[r_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_color   = m_left_reg;
    assign m_right_color  = m_right_reg;
    assign m_pixels_valid = m_pix_reg;

endmodule

### hw/rtl/slbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbr_checker
// Port-level checks of the line buffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module slbr_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [7:0]                  m_left_color,
    input  logic [7:0]                  m_right_color,
    input  logic                        m_pixels_valid
);

    // No result is pending right after reset.
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The queue is empty after reset, so intake is open.
    a_reset_intake_open: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_color) &&
            $stable(m_right_color) && $stable(m_pixels_valid))
        else $error("stalled result changed");

    // A result transaction without pixels carries zero colors.
    a_no_pixels_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pixels_valid |-> (m_left_color == 8'd0) &&
            (m_right_color == 8'd0))
        else $error("result without pixels carries colors");

endmodule

bind scanline_line_buffer_renderer slbr_checker u_checker (.*);
